FILE: hdl/efr_pkg.sv
package efr_pkg;

  // Frame buffer size in bytes, start and stop bytes included.
  localparam int BUF_BYTES = 64;
  localparam int CNT_W     = $clog2(BUF_BYTES + 1);
  localparam int LEN_W     = 7;
  localparam int LEN_MAX   = (1 << LEN_W) - 1;

  // Byte offsets of the captured fields inside a frame.
  localparam int OFS_TYPE  = 1;
  localparam int OFS_STATE = 10;
  localparam int OFS_RATE  = 14;
  localparam int OFS_MOVE  = 22;

  // Register indexes of the write port.
  localparam logic [1:0] REG_START  = 2'd0;
  localparam logic [1:0] REG_STOP   = 2'd1;
  localparam logic [1:0] REG_ESCAPE = 2'd2;
  localparam logic [1:0] REG_APP    = 2'd3;

  typedef enum logic [1:0] {
    MODE_HUNT,
    MODE_HUNT_SKIP,
    MODE_BODY,
    MODE_BODY_ESC
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_CHECKSUM,
    ST_START,
    ST_OVERFLOW
  } status_t;

  typedef struct packed {
    status_t            status;
    logic [LEN_W-1:0]   length;
    logic               is_app;
    logic [7:0]         state_b;
    logic [31:0]        rate;
    logic [31:0]        movement;
  } result_t;

endpackage

FILE: hdl/escaped_frame_receiver_xor_check_unit.sv
// Receiver for byte-stuffed frames with an XOR checksum.
// The input channel (in_valid, in_stall, rx_byte) carries one received
// serial byte per request. The output channel (out_valid, out_stall and the
// frame_* and word ports) carries one request at each frame end or abort:
// status, stored length, app-data flag, byte 10 and the little-endian words
// at offsets 14 and 22. Most input bytes produce no output request.
// The four code registers are written through wr_en, wr_index and wr_data;
// the user must write them only while the block is idle; the block does not enforce it.
// An accepted byte is held in the input register and is decoded into the
// result register when that register has room. One byte is accepted every
// cycle while the result register has room; the decode step is a single
// compare-and-XOR pass.
// Reset sets the codes to 125, 126, 127 and 0 and puts the receiver in the
// hunting state with both registers empty.
// While the receiver stalls, a held result stays put; the held input byte
// then waits only, and in_stall rises once the input register is also full.
module escaped_frame_receiver_xor_check_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [7:0]  wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  frame_status,
  output logic [6:0]  frame_length,
  output logic        is_app_data,
  output logic [7:0]  state_byte,
  output logic [31:0] rate_word,
  output logic [31:0] movement_word
);
  import efr_pkg::*;

  logic       byte_vld;
  logic [7:0] byte_q;
  logic       room;
  logic       step;
  logic       res_valid;
  result_t    res;
  result_t    res_q;

  assign step = byte_vld && room;

  efr_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .take     (step),
    .byte_vld (byte_vld),
    .byte_q   (byte_q)
  );

  efr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .step      (step),
    .b         (byte_q),
    .res_valid (res_valid),
    .res       (res)
  );

  efr_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .res       (res),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_q     (res_q)
  );

  assign frame_status  = res_q.status;
  assign frame_length  = res_q.length;
  assign is_app_data   = res_q.is_app;
  assign state_byte    = res_q.state_b;
  assign rate_word     = res_q.rate;
  assign movement_word = res_q.movement;

endmodule

FILE: hdl/efr_in_stage.sv
module efr_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       take,
  output logic       byte_vld,
  output logic [7:0] byte_q
);

  // The held byte leaves when the core takes it, so a new one may enter in
  // the same cycle.
  assign in_stall = byte_vld && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_vld <= 1'b0;
    end else if (!in_stall) begin
      byte_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_q <= rx_byte;
    end
  end

endmodule

FILE: hdl/efr_core.sv
module efr_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  logic [1:0]      wr_index,
  input  logic [7:0]      wr_data,
  input  logic            step,
  input  logic [7:0]      b,
  output logic            res_valid,
  output efr_pkg::result_t res
);
  import efr_pkg::*;

  logic [7:0]       start_code, stop_code, escape_code, app_code;
  mode_t            mode, mode_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [7:0]       running_xor, running_xor_next;
  logic [7:0]       last_byte, last_byte_next;
  logic [7:0]       type_byte, type_byte_next;
  logic [7:0]       cap_state, cap_state_next;
  logic [31:0]      cap_rate, cap_rate_next;
  logic [31:0]      cap_move, cap_move_next;

  logic             do_open, do_store, do_finish, do_emit;
  status_t          emit_status;
  logic             full;
  logic [CNT_W-1:0] cnt_base;
  logic [31:0]      cnt_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_code  <= 8'd125;
      stop_code   <= 8'd126;
      escape_code <= 8'd127;
      app_code    <= 8'd0;
    end else if (wr_en) begin
      case (wr_index)
        REG_START:  start_code  <= wr_data;
        REG_STOP:   stop_code   <= wr_data;
        REG_ESCAPE: escape_code <= wr_data;
        REG_APP:    app_code    <= wr_data;
        default:    ;
      endcase
    end
  end

  assign full = 32'(byte_count) >= 32'(BUF_BYTES);

  always_comb begin
    do_open     = 1'b0;
    do_store    = 1'b0;
    do_finish   = 1'b0;
    do_emit     = 1'b0;
    emit_status = ST_OK;
    mode_next   = mode;

    // Escape is tested before start, start before stop.
    case (mode)
      MODE_HUNT: begin
        if (b == escape_code) begin
          mode_next = MODE_HUNT_SKIP;
        end else if (b == start_code) begin
          do_open   = 1'b1;
          do_store  = 1'b1;
          mode_next = MODE_BODY;
        end
      end
      MODE_HUNT_SKIP: begin
        mode_next = MODE_HUNT;
      end
      MODE_BODY: begin
        if (b == escape_code) begin
          mode_next = MODE_BODY_ESC;
        end else if (b == start_code) begin
          do_emit     = 1'b1;
          emit_status = ST_START;
          mode_next   = MODE_HUNT;
        end else if (full) begin
          do_finish = 1'b1;
          mode_next = MODE_HUNT;
        end else begin
          do_store = 1'b1;
          if (b == stop_code) begin
            do_finish = 1'b1;
            mode_next = MODE_HUNT;
          end
        end
      end
      MODE_BODY_ESC: begin
        if (full) begin
          do_emit     = 1'b1;
          emit_status = ST_OVERFLOW;
          mode_next   = MODE_HUNT;
        end else begin
          do_store  = 1'b1;
          mode_next = MODE_BODY;
        end
      end
      default: mode_next = MODE_HUNT;
    endcase

    // A new frame starts from cleared fields.
    if (do_open) begin
      cnt_base         = '0;
      running_xor_next = 8'd0;
      last_byte_next   = 8'd0;
      type_byte_next   = 8'd0;
      cap_state_next   = 8'd0;
      cap_rate_next    = 32'd0;
      cap_move_next    = 32'd0;
    end else begin
      cnt_base         = byte_count;
      running_xor_next = running_xor;
      last_byte_next   = last_byte;
      type_byte_next   = type_byte;
      cap_state_next   = cap_state;
      cap_rate_next    = cap_rate;
      cap_move_next    = cap_move;
    end
    byte_count_next = cnt_base;

    if (do_store) begin
      if (cnt_base == CNT_W'(OFS_TYPE))  type_byte_next = b;
      if (cnt_base == CNT_W'(OFS_STATE)) cap_state_next = b;
      for (int k = 0; k < 4; k++) begin
        if (cnt_base == CNT_W'(OFS_RATE + k)) cap_rate_next[8*k +: 8] = b;
        if (cnt_base == CNT_W'(OFS_MOVE + k)) cap_move_next[8*k +: 8] = b;
      end
      running_xor_next = running_xor_next ^ b;
      last_byte_next   = b;
      byte_count_next  = cnt_base + CNT_W'(1);
    end

    // The XOR of all bytes up to the second-to-last is zero exactly when
    // the checksum byte matches the bytes before it.
    if (do_finish) begin
      do_emit     = 1'b1;
      emit_status = ((running_xor_next ^ last_byte_next) == 8'd0) ? ST_OK : ST_CHECKSUM;
    end

    cnt_ext      = 32'(byte_count_next);
    res.status   = emit_status;
    res.length   = (cnt_ext > 32'(LEN_MAX)) ? LEN_W'(LEN_MAX) : LEN_W'(byte_count_next);
    res.is_app   = (cnt_ext >= 32'd2) && (type_byte_next == app_code);
    res.state_b  = cap_state_next;
    res.rate     = cap_rate_next;
    res.movement = cap_move_next;
    res_valid    = step && do_emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_HUNT;
      byte_count  <= '0;
      running_xor <= 8'd0;
      last_byte   <= 8'd0;
      type_byte   <= 8'd0;
      cap_state   <= 8'd0;
      cap_rate    <= 32'd0;
      cap_move    <= 32'd0;
    end else if (step) begin
      mode        <= mode_next;
      byte_count  <= byte_count_next;
      running_xor <= running_xor_next;
      last_byte   <= last_byte_next;
      type_byte   <= type_byte_next;
      cap_state   <= cap_state_next;
      cap_rate    <= cap_rate_next;
      cap_move    <= cap_move_next;
    end
  end

endmodule

FILE: hdl/efr_out_stage.sv
module efr_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  efr_pkg::result_t res,
  output logic             room,
  output logic             out_valid,
  input  logic             out_stall,
  output efr_pkg::result_t res_q
);
  import efr_pkg::*;

  // The register can take a new result when empty or when its request
  // leaves in this cycle.
  assign room = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (room) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (room && load) begin
      res_q <= res;
    end
  end

endmodule
